### hdl/crk_pkg.sv
`timescale 1ns / 1ps
package crk_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int MAX_COMPARTMENTS = 32;
  localparam int MAX_COUPLINGS    = 64;
  localparam int IW               = $clog2(MAX_COMPARTMENTS);
  localparam int CIW              = $clog2(MAX_COUPLINGS);
  localparam int NW               = IW + 1;
  localparam int NCW              = CIW + 1;
  localparam int FW               = 4;
  localparam int AW               = FW + IW;

  localparam logic [31:0] FX_ONE = 32'(1) << FRAC_BITS;

  // divide-by-three unit: 48-bit dividend, eight quotient bits per cycle
  localparam int DIV_W      = 48;
  localparam int DIV_RADIX  = 8;
  localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
  localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(3) << (DIV_W - 2);
  localparam logic [DIV_W-1:0] DIV_UNBIAS = DIV_W'(1) << (DIV_W - 2);

  // item kinds
  localparam logic [2:0] K_PARAM    = 3'd0;
  localparam logic [2:0] K_COUPLING = 3'd1;
  localparam logic [2:0] K_STATE    = 3'd2;
  localparam logic [2:0] K_STIM     = 3'd3;
  localparam logic [2:0] K_ADVANCE  = 3'd4;

  // register indexes
  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_NCOMP = 2'd1;
  localparam logic [1:0] REG_NCPL  = 2'd2;

  localparam logic [30:0] STEP_RESET  = 31'd655;
  localparam logic [5:0]  NCOMP_RESET = 6'd32;
  localparam logic [6:0]  NCPL_RESET  = 7'd0;

  // word memory fields
  localparam logic [FW-1:0] F_U     = 4'd0;
  localparam logic [FW-1:0] F_V     = 4'd1;
  localparam logic [FW-1:0] F_ALPHA = 4'd2;
  localparam logic [FW-1:0] F_B     = 4'd3;
  localparam logic [FW-1:0] F_TAU   = 4'd4;
  localparam logic [FW-1:0] F_TAUR  = 4'd5;
  localparam logic [FW-1:0] F_NAX   = 4'd6;
  localparam logic [FW-1:0] F_SU    = 4'd7;
  localparam logic [FW-1:0] F_SV    = 4'd8;
  localparam logic [FW-1:0] F_SSU   = 4'd9;
  localparam logic [FW-1:0] F_SSV   = 4'd10;
  localparam logic [FW-1:0] F_KU    = 4'd11;
  localparam logic [FW-1:0] F_KV    = 4'd12;
  localparam logic [FW-1:0] F_CSUM  = 4'd13;
  localparam logic [FW-1:0] F_STIM0 = 4'd14;

  typedef struct packed {
    logic [30:0]    h;
    logic [NW-1:0]  n;
    logic [IW-1:0]  nm1;
    logic [NCW-1:0] nc;
  } cfg_t;

  typedef struct packed {
    logic        mul_go;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_sub;
    logic        div_go;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] mul_res;
    logic        mul_sat;
    logic [31:0] add_res;
    logic        add_sat;
    logic [31:0] div_res;
    logic        div_sat;
    logic        div_busy;
  } alu_rsp_t;

  typedef struct packed {
    logic [IW-1:0] compartment;
    logic [31:0]   u;
    logic [31:0]   v;
    logic          last;
    logic          ovf;
  } res_t;

  // saturate to 32 bits, flag in the top bit
  function automatic logic [32:0] sat64(input logic signed [63:0] x);
    logic [32:0] r;
    if (x > 64'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

endpackage

### hdl/coupled_dendrite_rk4_step_unit.sv
`timescale 1ns / 1ps
// Coupled dendrite network with one fourth-order Runge-Kutta step per advance item.
// Input channel (in_valid/in_ready) takes one item per transfer: parameter, coupling,
// initial-state, stimulus or advance. Output channel (out_valid/out_ready) carries one
// transfer per active compartment after an advance, in compartment order, last on the
// final one. Configuration goes through the APB port (step_size, active_dendrites,
// active_couplings at byte 0, 4, 8); write it only while the block is idle.
// Items are taken one at a time. An advance is paced by one shared 32x32 multiplier,
// one saturating adder, one word-memory read port and a divide-by-three unit that
// resolves eight quotient bits per cycle. A stalled receiver holds the result in the
// output register and pauses the step. Reset restores the registers, empties both
// stimulus tables and clears flags; compartment and coupling data are undefined until
// loaded.
module coupled_dendrite_rk4_step_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [5:0]  slot,
  input  logic [4:0]  source,
  input  logic [4:0]  target,
  input  logic        time_select,
  input  logic signed [31:0] value_a,
  input  logic signed [31:0] value_b,
  input  logic signed [31:0] value_c,
  input  logic signed [31:0] value_d,
  input  logic signed [31:0] value_e,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  compartment,
  output logic signed [31:0] u_out,
  output logic signed [31:0] v_out,
  output logic        last,
  output logic        overflow
);

  crk_pkg::cfg_t     cfg;
  crk_pkg::alu_req_t req;
  crk_pkg::alu_rsp_t rsp;
  crk_pkg::res_t     res;
  logic              res_valid, res_ready;

  crk_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  crk_alu u_alu (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  crk_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .slot(slot),
    .source(source), .target(target), .time_select(time_select),
    .value_a(value_a), .value_b(value_b), .value_c(value_c),
    .value_d(value_d), .value_e(value_e),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .req(req), .rsp(rsp)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      compartment <= res.compartment;
      u_out       <= res.u;
      v_out       <= res.v;
      last        <= res.last;
      overflow    <= res.ovf;
    end
  end

endmodule

### hdl/crk_regs.sv
`timescale 1ns / 1ps
module crk_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output crk_pkg::cfg_t      cfg
);

  logic [30:0] step_size;
  logic [5:0]  active_dendrites;
  logic [6:0]  active_couplings;
  logic [1:0]  ridx;
  logic [crk_pkg::NW-1:0] n;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= crk_pkg::STEP_RESET;
      active_dendrites <= crk_pkg::NCOMP_RESET;
      active_couplings <= crk_pkg::NCPL_RESET;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        crk_pkg::REG_STEP:  step_size        <= pwdata[30:0];
        crk_pkg::REG_NCOMP: active_dendrites <= pwdata[5:0];
        crk_pkg::REG_NCPL:  active_couplings <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      crk_pkg::REG_STEP:  prdata = {1'b0, step_size};
      crk_pkg::REG_NCOMP: prdata = {26'd0, active_dendrites};
      crk_pkg::REG_NCPL:  prdata = {25'd0, active_couplings};
      default:            prdata = 32'd0;
    endcase
  end

  // clamp counts to the supported range
  always_comb begin
    if (active_dendrites == 6'd0) n = crk_pkg::NW'(1);
    else if (active_dendrites > 6'(crk_pkg::MAX_COMPARTMENTS))
      n = crk_pkg::NW'(crk_pkg::MAX_COMPARTMENTS);
    else n = crk_pkg::NW'(active_dendrites);
    cfg.h   = step_size;
    cfg.n   = n;
    cfg.nm1 = crk_pkg::IW'(n - crk_pkg::NW'(1));
    if (active_couplings > 7'(crk_pkg::MAX_COUPLINGS))
      cfg.nc = crk_pkg::NCW'(crk_pkg::MAX_COUPLINGS);
    else cfg.nc = crk_pkg::NCW'(active_couplings);
  end

endmodule

### hdl/crk_alu.sv
`timescale 1ns / 1ps
module crk_alu (
  input  logic              clk,
  input  logic              rst,
  input  crk_pkg::alu_req_t req,
  output crk_pkg::alu_rsp_t rsp
);

  logic signed [63:0] prod;
  logic signed [63:0] prod_sh;
  logic [32:0]        ms;
  logic signed [63:0] sum;
  logic [32:0]        as_r;
  logic [crk_pkg::DIV_W-1:0] dy, dq, dy_n, dq_n, dvd;
  logic [1:0]         dr, dr_n;
  logic [2:0]         dcnt;
  logic [2:0]         t;
  logic signed [crk_pkg::DIV_W-1:0] qs;
  logic [32:0]        ds;

  always_ff @(posedge clk) begin
    if (req.mul_go) prod <= $signed(req.mul_a) * $signed(req.mul_b);
  end

  assign prod_sh = prod >>> crk_pkg::FRAC_BITS;
  assign ms      = crk_pkg::sat64(prod_sh);

  always_comb begin
    if (req.add_sub)
      sum = 64'($signed(req.add_a)) - 64'($signed(req.add_b));
    else
      sum = 64'($signed(req.add_a)) + 64'($signed(req.add_b));
  end
  assign as_r = crk_pkg::sat64(sum);

  // floor(prod / 2^(FRAC_BITS+1)), biased positive for the divide by three
  assign dvd = crk_pkg::DIV_W'(prod >>> (crk_pkg::FRAC_BITS + 1)) + crk_pkg::DIV_BIAS;

  always_comb begin
    dr_n = dr;
    dy_n = dy;
    dq_n = dq;
    t    = 3'd0;
    for (int j = 0; j < crk_pkg::DIV_RADIX; j++) begin
      t    = {dr_n, dy_n[crk_pkg::DIV_W-1]};
      dy_n = {dy_n[crk_pkg::DIV_W-2:0], 1'b0};
      if (t >= 3'd3) begin
        dq_n = {dq_n[crk_pkg::DIV_W-2:0], 1'b1};
        dr_n = 2'(t - 3'd3);
      end else begin
        dq_n = {dq_n[crk_pkg::DIV_W-2:0], 1'b0};
        dr_n = t[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= 3'd0;
    end else if (req.div_go) begin
      dcnt <= 3'(crk_pkg::DIV_STEPS);
    end else if (dcnt != 3'd0) begin
      dcnt <= dcnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.div_go) begin
      dy <= dvd;
      dq <= '0;
      dr <= 2'd0;
    end else if (dcnt != 3'd0) begin
      dy <= dy_n;
      dq <= dq_n;
      dr <= dr_n;
    end
  end

  assign qs = $signed(dq - crk_pkg::DIV_UNBIAS);
  assign ds = crk_pkg::sat64(64'(qs));

  always_comb begin
    rsp.mul_res  = ms[31:0];
    rsp.mul_sat  = ms[32];
    rsp.add_res  = as_r[31:0];
    rsp.add_sat  = as_r[32];
    rsp.div_res  = ds[31:0];
    rsp.div_sat  = ds[32];
    rsp.div_busy = (dcnt != 3'd0);
  end

endmodule

### hdl/crk_core.sv
`timescale 1ns / 1ps
module crk_core (
  input  logic              clk,
  input  logic              rst,
  input  crk_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        kind,
  input  logic [5:0]        slot,
  input  logic [4:0]        source,
  input  logic [4:0]        target,
  input  logic              time_select,
  input  logic [31:0]       value_a,
  input  logic [31:0]       value_b,
  input  logic [31:0]       value_c,
  input  logic [31:0]       value_d,
  input  logic [31:0]       value_e,
  output logic              res_valid,
  input  logic              res_ready,
  output crk_pkg::res_t     res,
  output crk_pkg::alu_req_t req,
  input  crk_pkg::alu_rsp_t rsp
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_STIM = 4'd2;
  localparam logic [3:0] ST_INIT = 4'd3;
  localparam logic [3:0] ST_CPL  = 4'd4;
  localparam logic [3:0] ST_SLP  = 4'd5;
  localparam logic [3:0] ST_UPD  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_SWAP = 4'd8;

  localparam int MC = crk_pkg::MAX_COMPARTMENTS;
  localparam int IW = crk_pkg::IW;

  logic [3:0]  st;
  logic [3:0]  stp;
  logic [IW-1:0] idx;
  logic [crk_pkg::CIW-1:0] cidx;
  logic [1:0]  stage;
  logic        now_bank;
  logic [2*MC-1:0] stim_vld;
  logic [MC-1:0]   csum_vld;
  logic [MC-1:0]   sflag;
  logic [MC-1:0]   ovf;

  logic [2:0]  it_kind;
  logic [5:0]  it_slot;
  logic [4:0]  it_src, it_tgt;
  logic        it_ts;
  logic [31:0] it_a, it_b, it_c, it_d, it_e;
  logic [31:0] ru, rv, rna, rtau, rtaur, rb, rku, rkv, t1, t2, rnu, rnv;

  logic [31:0] wmem [2**crk_pkg::AW];
  logic [41:0] cmem [crk_pkg::MAX_COUPLINGS];
  logic [31:0] mem_q, q;
  logic        rd_zero;
  logic [41:0] cq;
  logic [4:0]  cq_src, cq_tgt;
  logic [31:0] cq_gain;

  logic [crk_pkg::AW-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wdata;
  logic        use_add, use_mul, use_div, sat_hit;
  logic [IW-1:0] sat_idx;
  logic [IW-1:0] sidx;
  logic        slot_ok, cslot_ok, cpl_skip, cpl_last, idx_last;
  logic        weight2, first, has_h, upd_end, fin_go;
  logic [31:0] h32, hstep;
  logic [crk_pkg::FW-1:0] stim_now_f, stim_next_f, stim_sel_f;
  logic [crk_pkg::FW-1:0] rfld;
  logic        rd_zero_next;

  assign in_ready  = (st == ST_IDLE);
  assign sidx      = it_slot[IW-1:0];
  assign slot_ok   = ({1'b0, slot} < 7'(MC));
  assign cslot_ok  = ({1'b0, slot} < 7'(crk_pkg::MAX_COUPLINGS));
  assign cq_src    = cq[41:37];
  assign cq_tgt    = cq[36:32];
  assign cq_gain   = cq[31:0];
  assign cpl_skip  = !(6'(cq_src) < 6'(cfg.n)) || !(6'(cq_tgt) < 6'(cfg.n));
  assign cpl_last  = ((crk_pkg::NCW'(cidx) + crk_pkg::NCW'(1)) == cfg.nc);
  assign idx_last  = (idx == cfg.nm1);
  assign weight2   = (stage == 2'd1) || (stage == 2'd2);
  assign first     = (stage == 2'd0);
  assign has_h     = (stage != 2'd3);
  assign upd_end   = (stp == 4'd7) || (stp == 4'd5 && !has_h);
  assign h32       = {1'b0, cfg.h};
  assign hstep     = (stage == 2'd2) ? h32 : {2'b0, cfg.h[30:1]};
  assign fin_go    = !rsp.div_busy;
  assign stim_now_f  = {crk_pkg::F_STIM0[3:1], now_bank};
  assign stim_next_f = {crk_pkg::F_STIM0[3:1], ~now_bank};
  assign stim_sel_f  = (stage == 2'd3) ? stim_next_f : stim_now_f;
  assign q         = rd_zero ? 32'd0 : mem_q;

  // address, write and arithmetic control per step
  always_comb begin
    raddr   = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    req     = '0;
    use_add = 1'b0;
    use_mul = 1'b0;
    use_div = 1'b0;
    sat_idx = idx;
    res_valid = 1'b0;
    case (st)
      ST_LOAD: begin
        we    = (it_kind != crk_pkg::K_COUPLING);
        if (it_kind == crk_pkg::K_PARAM) begin
          case (stp)
            4'd0:    begin waddr = {crk_pkg::F_ALPHA, sidx}; wdata = it_a; end
            4'd1:    begin waddr = {crk_pkg::F_B, sidx};     wdata = it_b; end
            4'd2:    begin waddr = {crk_pkg::F_TAU, sidx};   wdata = it_c; end
            4'd3:    begin waddr = {crk_pkg::F_TAUR, sidx};  wdata = it_d; end
            default: begin waddr = {crk_pkg::F_NAX, sidx};   wdata = it_e; end
          endcase
        end else if (stp == 4'd0) begin
          waddr = {crk_pkg::F_U, sidx};
          wdata = it_a;
        end else begin
          waddr = {crk_pkg::F_V, sidx};
          wdata = it_b;
        end
      end
      ST_STIM: begin
        raddr = {(it_ts ? stim_next_f : stim_now_f), sidx};
        if (stp == 4'd1) begin
          req.add_a = q;
          req.add_b = it_a;
          we    = 1'b1;
          waddr = raddr;
          wdata = rsp.add_res;
        end
      end
      ST_INIT: begin
        case (stp)
          4'd0: raddr = {crk_pkg::F_U, idx};
          4'd1: begin
            raddr = {crk_pkg::F_V, idx};
            we = 1'b1; waddr = {crk_pkg::F_SU, idx}; wdata = q;
          end
          default: begin
            we = 1'b1; waddr = {crk_pkg::F_SV, idx}; wdata = q;
          end
        endcase
      end
      ST_CPL: begin
        sat_idx = cq_src;
        case (stp)
          4'd1: raddr = {crk_pkg::F_SU, cq_tgt};
          4'd2: raddr = {crk_pkg::F_SU, cq_src};
          4'd3: begin
            raddr = {crk_pkg::F_CSUM, cq_src};
            req.add_a = ru; req.add_b = q; req.add_sub = 1'b1; use_add = 1'b1;
          end
          4'd4: begin
            req.mul_go = 1'b1; req.mul_a = cq_gain; req.mul_b = t1;
          end
          4'd5: begin
            req.add_a = t2; req.add_b = rsp.mul_res; use_add = 1'b1; use_mul = 1'b1;
            we = 1'b1; waddr = {crk_pkg::F_CSUM, cq_src}; wdata = rsp.add_res;
          end
          default: ;
        endcase
      end
      ST_SLP: begin
        case (stp)
          4'd0: raddr = {crk_pkg::F_SU, idx};
          4'd1: raddr = {crk_pkg::F_SV, idx};
          4'd2: raddr = {crk_pkg::F_ALPHA, idx};
          4'd3: begin
            raddr = {crk_pkg::F_NAX, idx};
            req.mul_go = 1'b1; req.mul_a = q; req.mul_b = ru;
            req.add_a = ru; req.add_b = crk_pkg::FX_ONE; req.add_sub = 1'b1;
            use_add = 1'b1;
          end
          4'd4: begin
            raddr = {crk_pkg::F_TAU, idx};
            req.add_a = crk_pkg::FX_ONE; req.add_b = rsp.mul_res; req.add_sub = 1'b1;
            use_add = 1'b1; use_mul = 1'b1;
            req.mul_go = 1'b1; req.mul_a = ru; req.mul_b = t1;
          end
          4'd5: begin
            raddr = {crk_pkg::F_TAUR, idx};
            req.mul_go = 1'b1; req.mul_a = rsp.mul_res; req.mul_b = t2; use_mul = 1'b1;
          end
          4'd6: begin
            raddr = {crk_pkg::F_B, idx};
            req.add_a = rsp.mul_res; req.add_b = rv; req.add_sub = 1'b1;
            use_add = 1'b1; use_mul = 1'b1;
          end
          4'd7: begin
            raddr = {crk_pkg::F_CSUM, idx};
            req.mul_go = 1'b1; req.mul_a = rna; req.mul_b = t1;
          end
          4'd8: begin
            raddr = {stim_sel_f, idx};
            req.mul_go = 1'b1; req.mul_a = rtaur; req.mul_b = rb; use_mul = 1'b1;
          end
          4'd9: begin
            req.mul_go = 1'b1; req.mul_a = rsp.mul_res; req.mul_b = ru; use_mul = 1'b1;
            req.add_a = t1; req.add_b = t2; use_add = 1'b1;
          end
          4'd10: begin
            req.add_a = t1; req.add_b = t2; use_add = 1'b1; use_mul = 1'b1;
            we = 1'b1; waddr = {crk_pkg::F_KV, idx}; wdata = rsp.mul_res;
          end
          4'd11: begin
            req.mul_go = 1'b1; req.mul_a = rtau; req.mul_b = t1;
          end
          4'd12: begin
            use_mul = 1'b1;
            we = 1'b1; waddr = {crk_pkg::F_KU, idx}; wdata = rsp.mul_res;
          end
          default: ;
        endcase
      end
      ST_UPD: begin
        case (stp)
          4'd0: raddr = {crk_pkg::F_KU, idx};
          4'd1: raddr = {crk_pkg::F_KV, idx};
          4'd2: begin
            raddr = {crk_pkg::F_SSU, idx};
            req.add_a = rku; req.add_b = rku; use_add = weight2;
          end
          4'd3: begin
            raddr = {crk_pkg::F_SSV, idx};
            req.add_a = q; req.add_b = t1; use_add = !first;
            we = 1'b1; waddr = {crk_pkg::F_SSU, idx};
            wdata = first ? t1 : rsp.add_res;
          end
          4'd4: begin
            raddr = {crk_pkg::F_U, idx};
            req.add_a = rkv; req.add_b = rkv; use_add = weight2;
          end
          4'd5: begin
            raddr = {crk_pkg::F_V, idx};
            req.add_a = t2; req.add_b = t1; use_add = !first;
            we = 1'b1; waddr = {crk_pkg::F_SSV, idx};
            wdata = first ? t1 : rsp.add_res;
            req.mul_go = has_h; req.mul_a = hstep; req.mul_b = rku;
          end
          4'd6: begin
            req.add_a = ru; req.add_b = rsp.mul_res; use_add = 1'b1; use_mul = 1'b1;
            we = 1'b1; waddr = {crk_pkg::F_SU, idx}; wdata = rsp.add_res;
            req.mul_go = 1'b1; req.mul_a = hstep; req.mul_b = rkv;
          end
          4'd7: begin
            req.add_a = rv; req.add_b = rsp.mul_res; use_add = 1'b1; use_mul = 1'b1;
            we = 1'b1; waddr = {crk_pkg::F_SV, idx}; wdata = rsp.add_res;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        case (stp)
          4'd0: raddr = {crk_pkg::F_SSU, idx};
          4'd1: begin
            raddr = {crk_pkg::F_SSV, idx};
            req.mul_go = 1'b1; req.mul_a = h32; req.mul_b = q;
          end
          4'd2: begin
            raddr = {crk_pkg::F_U, idx};
            req.div_go = 1'b1;
            req.mul_go = 1'b1; req.mul_a = h32; req.mul_b = q;
          end
          4'd3: raddr = {crk_pkg::F_V, idx};
          4'd5: begin
            req.add_a = ru; req.add_b = rsp.div_res;
            use_add = fin_go; use_div = fin_go; req.div_go = fin_go;
            we = fin_go; waddr = {crk_pkg::F_U, idx}; wdata = rsp.add_res;
          end
          4'd6: begin
            req.add_a = rv; req.add_b = rsp.div_res;
            use_add = fin_go; use_div = fin_go;
            we = fin_go; waddr = {crk_pkg::F_V, idx}; wdata = rsp.add_res;
          end
          4'd7: res_valid = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    sat_hit = (use_add && rsp.add_sat) || (use_mul && rsp.mul_sat) ||
              (use_div && rsp.div_sat);
  end

  assign res.compartment = idx;
  assign res.u           = rnu;
  assign res.v           = rnv;
  assign res.last        = idx_last;
  assign res.ovf         = ovf[idx];

  // entries of the stimulus tables and coupling sums not yet written read as zero
  assign rfld = raddr[crk_pkg::AW-1:IW];
  always_comb begin
    if (rfld == crk_pkg::F_CSUM) rd_zero_next = !csum_vld[raddr[IW-1:0]];
    else if (rfld[3:1] == crk_pkg::F_STIM0[3:1]) rd_zero_next = !stim_vld[raddr[IW:0]];
    else rd_zero_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (we) wmem[waddr] <= wdata;
    mem_q   <= wmem[raddr];
    rd_zero <= rd_zero_next;
    if (st == ST_LOAD && it_kind == crk_pkg::K_COUPLING)
      cmem[it_slot[crk_pkg::CIW-1:0]] <= {it_src, it_tgt, it_a};
    cq <= cmem[cidx];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      stp      <= 4'd0;
      idx      <= '0;
      cidx     <= '0;
      stage    <= 2'd0;
      now_bank <= 1'b0;
      stim_vld <= '0;
      csum_vld <= '0;
      sflag    <= '0;
      ovf      <= '0;
    end else begin
      if (sat_hit) ovf[sat_idx] <= 1'b1;
      case (st)
        ST_IDLE: begin
          stp   <= 4'd0;
          idx   <= '0;
          cidx  <= '0;
          stage <= 2'd0;
          if (in_valid) begin
            case (kind)
              crk_pkg::K_PARAM, crk_pkg::K_STATE: if (slot_ok) st <= ST_LOAD;
              crk_pkg::K_COUPLING: if (cslot_ok) st <= ST_LOAD;
              crk_pkg::K_STIM: if (slot_ok) st <= ST_STIM;
              crk_pkg::K_ADVANCE: begin
                st  <= ST_INIT;
                ovf <= sflag;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          stp <= stp + 4'd1;
          if ((it_kind == crk_pkg::K_PARAM && stp == 4'd4) ||
              (it_kind == crk_pkg::K_STATE && stp == 4'd1) ||
              it_kind == crk_pkg::K_COUPLING)
            st <= ST_IDLE;
        end
        ST_STIM: begin
          stp <= stp + 4'd1;
          if (stp == 4'd1) begin
            stim_vld[{(it_ts ? ~now_bank : now_bank), sidx}] <= 1'b1;
            if (rsp.add_sat) sflag[sidx] <= 1'b1;
            st <= ST_IDLE;
          end
        end
        ST_INIT: begin
          if (stp == 4'd2) begin
            stp <= 4'd0;
            if (idx_last) begin
              idx      <= '0;
              cidx     <= '0;
              csum_vld <= '0;
              st       <= (cfg.nc == '0) ? ST_SLP : ST_CPL;
            end else idx <= idx + IW'(1);
          end else stp <= stp + 4'd1;
        end
        ST_CPL: begin
          if ((stp == 4'd1 && cpl_skip) || stp == 4'd5) begin
            if (stp == 4'd5) csum_vld[cq_src] <= 1'b1;
            stp <= 4'd0;
            if (cpl_last) begin
              st  <= ST_SLP;
              idx <= '0;
            end else cidx <= cidx + crk_pkg::CIW'(1);
          end else stp <= stp + 4'd1;
        end
        ST_SLP: begin
          if (stp == 4'd12) begin
            stp <= 4'd0;
            if (idx_last) begin
              st  <= ST_UPD;
              idx <= '0;
            end else idx <= idx + IW'(1);
          end else stp <= stp + 4'd1;
        end
        ST_UPD: begin
          if (upd_end) begin
            stp <= 4'd0;
            idx <= (idx_last) ? '0 : idx + IW'(1);
            if (idx_last) begin
              if (stage == 2'd3) st <= ST_FIN;
              else begin
                stage    <= stage + 2'd1;
                cidx     <= '0;
                csum_vld <= '0;
                st       <= (cfg.nc == '0) ? ST_SLP : ST_CPL;
              end
            end
          end else stp <= stp + 4'd1;
        end
        ST_FIN: begin
          case (stp)
            4'd5, 4'd6: if (fin_go) stp <= stp + 4'd1;
            4'd7: begin
              if (res_ready) begin
                stp <= 4'd0;
                if (idx_last) st <= ST_SWAP;
                else idx <= idx + IW'(1);
              end
            end
            default: stp <= stp + 4'd1;
          endcase
        end
        ST_SWAP: begin
          // next-time table becomes current; the old current bank is emptied
          now_bank <= ~now_bank;
          stim_vld[{now_bank, IW'(0)} +: MC] <= '0;
          sflag <= '0;
          st    <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (in_valid) begin
          it_kind <= kind;
          it_slot <= slot;
          it_src  <= source;
          it_tgt  <= target;
          it_ts   <= time_select;
          it_a    <= value_a;
          it_b    <= value_b;
          it_c    <= value_c;
          it_d    <= value_d;
          it_e    <= value_e;
        end
      end
      ST_CPL: begin
        case (stp)
          4'd2: ru <= q;
          4'd3: t1 <= rsp.add_res;
          4'd4: t2 <= q;
          default: ;
        endcase
      end
      ST_SLP: begin
        case (stp)
          4'd1: ru <= q;
          4'd2: rv <= q;
          4'd3: t1 <= rsp.add_res;
          4'd4: begin rna <= q; t2 <= rsp.add_res; end
          4'd5: rtau <= q;
          4'd6: begin rtaur <= q; t1 <= rsp.add_res; end
          4'd7: rb <= q;
          4'd8: begin t2 <= q; t1 <= rsp.mul_res; end
          4'd9: begin t1 <= rsp.add_res; t2 <= q; end
          4'd10: t1 <= rsp.add_res;
          default: ;
        endcase
      end
      ST_UPD: begin
        case (stp)
          4'd1: rku <= q;
          4'd2: begin rkv <= q; t1 <= weight2 ? rsp.add_res : rku; end
          4'd4: begin t2 <= q; t1 <= weight2 ? rsp.add_res : rkv; end
          4'd5: ru <= q;
          4'd6: rv <= q;
          default: ;
        endcase
      end
      ST_FIN: begin
        case (stp)
          4'd3: ru <= q;
          4'd4: rv <= q;
          4'd5: if (fin_go) rnu <= rsp.add_res;
          4'd6: if (fin_go) rnv <= rsp.add_res;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
